// ----- src/assert_macros.svh -----
// Assertion macros shared by the trajectory evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/pptev_pkg.sv -----
// Shared types, constants and functions of the trajectory evaluator.
package pptev_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int SEG_W        = 4;
  localparam int NUM_COEFFS   = 8;

  localparam logic [2:0] COEFF_TOP  = 3'(NUM_COEFFS - 1);
  localparam logic [2:0] DERIV_LAST = 3'd4;
  localparam logic [4:0] SEG_LIMIT  = 5'(MAX_SEGMENTS);

  localparam logic [63:0] SAT_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    REQ_COEFF  = 2'd0,
    REQ_TIMING = 2'd1,
    REQ_EVAL   = 2'd2
  } req_t;

  localparam logic CFG_SEG_COUNT = 1'b0;
  localparam logic CFG_END_TIME  = 1'b1;

  typedef enum logic {
    FR_IDLE,
    FR_SEARCH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_T,
    BK_FIX_T,
    BK_MUL_K,
    BK_FIX_K,
    BK_ADD,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic             is_eval;
    logic [SEG_W-1:0] seg;
    logic [1:0]       axis;
    logic [2:0]       ci;
    logic [63:0]      value;
    logic [31:0]      t;
  } job_t;

  // i*(i-1)*...*(i-d+1)
  function automatic logic [9:0] deriv_gain(input logic [2:0] i, input logic [2:0] d);
    logic [9:0] k;
    k = 10'd1;
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < d) k = 10'(k * (10'(i) - 10'(j)));
    end
    return k;
  endfunction

endpackage

// ----- src/pptev_queue.sv -----
// Two-entry job queue between the front and the back.
`include "assert_macros.svh"
module pptev_queue
  import pptev_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  input  job_t q_wdata,
  output logic q_full,
  input  logic q_pop,
  output job_t q_rdata,
  output logic q_empty
);

  job_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_rdata = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = q_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = 2'(cnt_r + 2'(q_push) - 2'(q_pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      entry_r[wr_ptr_r] <= q_wdata;
    end
  end

  `ASSERT_NEVER(a_q_overflow, q_push && q_full, "job pushed into full queue")
  `ASSERT_NEVER(a_q_underflow, q_pop && q_empty, "job popped from empty queue")

endmodule

// ----- src/pptev_front.sv -----
// Front end: input transfers, configuration, timing store and segment search.
`include "assert_macros.svh"
module pptev_front
  import pptev_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_segment,
  input  logic [1:0]  in_axis,
  input  logic [2:0]  in_coeff_index,
  input  logic [63:0] in_coeff_value,
  input  logic [31:0] in_seg_start,
  input  logic [31:0] in_seg_length,
  input  logic [31:0] in_query_time,
  output logic        q_push,
  output job_t        q_wdata,
  input  logic        q_full
);

  front_state_t     state_r, state_nxt;
  logic [4:0]       seg_count_r;
  logic [31:0]      end_time_r;
  logic [31:0]      start_r [MAX_SEGMENTS];
  logic [31:0]      len_r   [MAX_SEGMENTS];
  logic [31:0]      tq_r;
  logic [4:0]       count_r;
  logic [SEG_W-1:0] s_r;

  logic        accept;
  logic [4:0]  count_clamp;
  logic [31:0] tq_clamp;
  logic [32:0] win_end;
  logic        hit;
  logic        is_last;
  logic        found;

  assign full    = (state_r != FR_IDLE) || q_full;
  assign accept  = push && !full;

  assign count_clamp = (seg_count_r == 5'd0) ? 5'd1 :
                       (seg_count_r > SEG_LIMIT) ? SEG_LIMIT : seg_count_r;
  assign tq_clamp    = (in_query_time > end_time_r) ? end_time_r : in_query_time;

  assign win_end = 33'(start_r[s_r]) + 33'(len_r[s_r]);
  assign hit     = (tq_r >= start_r[s_r]) && (33'(tq_r) <= win_end);
  assign is_last = (5'(s_r) == 5'(count_r - 5'd1));
  assign found   = hit || is_last;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_IDLE: begin
        if (accept && in_req_type == REQ_EVAL) state_nxt = FR_SEARCH;
      end
      FR_SEARCH: begin
        if (found && !q_full) state_nxt = FR_IDLE;
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    q_push  = 1'b0;
    q_wdata = '0;
    unique case (state_r)
      FR_IDLE: begin
        q_push        = accept && (in_req_type == REQ_COEFF);
        q_wdata.seg   = in_segment;
        q_wdata.axis  = in_axis;
        q_wdata.ci    = in_coeff_index;
        q_wdata.value = in_coeff_value;
      end
      FR_SEARCH: begin
        q_push          = found && !q_full;
        q_wdata.is_eval = 1'b1;
        q_wdata.seg     = s_r;
        q_wdata.t       = hit ? 32'(tq_r - start_r[s_r]) : len_r[s_r];
      end
      default: q_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FR_IDLE;
      seg_count_r <= 5'd1;
      end_time_r  <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_SEG_COUNT: seg_count_r <= cfg_data[4:0];
          CFG_END_TIME:  end_time_r  <= cfg_data;
          default:       end_time_r  <= end_time_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_req_type == REQ_TIMING) begin
      start_r[in_segment] <= in_seg_start;
      len_r[in_segment]   <= in_seg_length;
    end
    if (accept && in_req_type == REQ_EVAL) begin
      tq_r    <= tq_clamp;
      count_r <= count_clamp;
      s_r     <= '0;
    end else if (state_r == FR_SEARCH && !found) begin
      s_r <= SEG_W'(s_r + 1'b1);
    end
  end

  `ASSERT_CLK(a_scan_in_range, (state_r == FR_SEARCH) |-> (5'(s_r) < count_r),
              "segment scan ran past segment count")

endmodule

// ----- src/pptev_back.sv -----
// Back end: coefficient memory, Horner evaluator and result register.
`include "assert_macros.svh"
module pptev_back
  import pptev_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  job_t        q_rdata,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_deriv_order,
  output logic [63:0] out_x,
  output logic [63:0] out_y,
  output logic [63:0] out_z,
  output logic [63:0] out_yaw,
  output logic        out_last
);

  back_state_t      state_r, state_nxt;
  logic [63:0]      mem [MAX_SEGMENTS * 4 * NUM_COEFFS];
  logic [63:0]      rd_data_r;
  logic [SEG_W-1:0] seg_r;
  logic [31:0]      t_r;
  logic [2:0]       d_r;
  logic [1:0]       ax_r;
  logic [2:0]       i_r;
  logic [63:0]      acc_r;
  logic [63:0]      term_r;
  logic [63:0]      p_lo_r, p_hi_r;
  logic             neg_r;
  logic [63:0]      res_r [4];
  logic             out_valid_r;

  logic        mem_we;
  logic        out_load;
  logic [63:0] mul_src;
  logic        mul_neg;
  logic [63:0] mul_mag;
  logic [31:0] mul_b;
  logic [95:0] prod;
  logic [74:0] mag_t;
  logic [64:0] sum;
  logic [63:0] sum_sat;
  logic [1:0]  last_ax;
  logic        poly_done;
  logic        run_done;

  function automatic logic [63:0] sat_mag(input logic [74:0] mag, input logic neg);
    logic [63:0] r;
    if (!neg) begin
      r = (mag > 75'(SAT_MAX)) ? SAT_MAX : mag[63:0];
    end else begin
      r = (mag > 75'(SAT_MIN)) ? SAT_MIN : 64'(64'd0 - mag[63:0]);
    end
    return r;
  endfunction

  assign mul_src = (state_r == BK_MUL_T) ? acc_r : rd_data_r;
  assign mul_neg = mul_src[63];
  assign mul_mag = mul_neg ? 64'(64'd0 - mul_src) : mul_src;
  assign mul_b   = (state_r == BK_MUL_T) ? t_r : 32'(deriv_gain(i_r, d_r));

  assign prod    = {32'd0, p_lo_r} + {p_hi_r, 32'd0};
  assign mag_t   = 75'(prod[95:24]) + 75'(neg_r && (prod[23:0] != 24'd0));

  assign sum     = {acc_r[63], acc_r} + {term_r[63], term_r};
  assign sum_sat = (sum[64] != sum[63]) ? (sum[64] ? SAT_MIN : SAT_MAX) : sum[63:0];

  assign last_ax   = (d_r < 3'd2) ? 2'd3 : 2'd2;
  assign poly_done = (i_r == d_r);
  assign run_done  = poly_done && (ax_r == last_ax);

  assign empty = !out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty && q_rdata.is_eval) state_nxt = BK_MUL_T;
      end
      BK_MUL_T: state_nxt = BK_FIX_T;
      BK_FIX_T: state_nxt = BK_MUL_K;
      BK_MUL_K: state_nxt = BK_FIX_K;
      BK_FIX_K: state_nxt = BK_ADD;
      BK_ADD:   state_nxt = run_done ? BK_EMIT : BK_MUL_T;
      BK_EMIT: begin
        if (out_load) state_nxt = (d_r == DERIV_LAST) ? BK_IDLE : BK_MUL_T;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state_r == BK_IDLE) && !q_empty;
    mem_we   = q_pop && !q_rdata.is_eval;
    out_load = (state_r == BK_EMIT) && (!out_valid_r || pop);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{q_rdata.seg, q_rdata.axis, q_rdata.ci}] <= q_rdata.value;
    end
    rd_data_r <= mem[{seg_r, ax_r, i_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        seg_r <= q_rdata.seg;
        t_r   <= q_rdata.t;
        d_r   <= 3'd0;
        ax_r  <= 2'd0;
        i_r   <= COEFF_TOP;
        acc_r <= 64'd0;
      end
      BK_MUL_T, BK_MUL_K: begin
        p_lo_r <= 64'(mul_mag[31:0]) * 64'(mul_b);
        p_hi_r <= 64'(mul_mag[63:32]) * 64'(mul_b);
        neg_r  <= mul_neg;
      end
      BK_FIX_T: acc_r  <= sat_mag(mag_t, neg_r);
      BK_FIX_K: term_r <= sat_mag(prod[74:0], neg_r);
      BK_ADD: begin
        if (poly_done) begin
          res_r[ax_r] <= sum_sat;
          acc_r       <= 64'd0;
          ax_r        <= 2'(ax_r + 2'd1);
          i_r         <= COEFF_TOP;
        end else begin
          acc_r <= sum_sat;
          i_r   <= 3'(i_r - 3'd1);
        end
      end
      BK_EMIT: begin
        if (out_load) begin
          out_deriv_order <= d_r;
          out_x           <= res_r[0];
          out_y           <= res_r[1];
          out_z           <= res_r[2];
          out_yaw         <= (d_r < 3'd2) ? res_r[3] : 64'd0;
          out_last        <= (d_r == DERIV_LAST);
          d_r             <= 3'(d_r + 3'd1);
          ax_r            <= 2'd0;
          i_r             <= COEFF_TOP;
        end
      end
      default: acc_r <= acc_r;
    endcase
  end

  `ASSERT_CLK(a_horner_index,
              (state_r != BK_IDLE && state_r != BK_EMIT) |-> (i_r >= d_r),
              "Horner index dropped below derivative order")

endmodule

// ----- src/piecewise_poly_trajectory_eval_top.sv -----
// Top level of the piecewise polynomial trajectory evaluator.
// A query runs in the back end as 105 Horner steps (four axes at orders 0
// and 1, three at orders 2 to 4), each through the states MUL_T, FIX_T,
// MUL_K, FIX_K and ADD on one shared pair of 32x32 multipliers, and an
// EMIT state hands out each result. The front searches segments at one per
// cycle (up to 16) and a two-entry queue lets it run ahead of the evaluator.
// Results of one query come out as five transfers, orders 0 to 4, with last
// set on the fifth.
module piecewise_poly_trajectory_eval_top
  import pptev_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_segment,
  input  logic [1:0]  in_axis,
  input  logic [2:0]  in_coeff_index,
  input  logic [63:0] in_coeff_value,
  input  logic [31:0] in_seg_start,
  input  logic [31:0] in_seg_length,
  input  logic [31:0] in_query_time,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_deriv_order,
  output logic [63:0] out_x,
  output logic [63:0] out_y,
  output logic [63:0] out_z,
  output logic [63:0] out_yaw,
  output logic        out_last
);

  logic q_push, q_full, q_pop, q_empty;
  job_t q_wdata, q_rdata;

  pptev_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .in_req_type    (in_req_type),
    .in_segment     (in_segment),
    .in_axis        (in_axis),
    .in_coeff_index (in_coeff_index),
    .in_coeff_value (in_coeff_value),
    .in_seg_start   (in_seg_start),
    .in_seg_length  (in_seg_length),
    .in_query_time  (in_query_time),
    .q_push         (q_push),
    .q_wdata        (q_wdata),
    .q_full         (q_full)
  );

  pptev_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  pptev_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rdata         (q_rdata),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_deriv_order (out_deriv_order),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .out_yaw         (out_yaw),
    .out_last        (out_last)
  );

endmodule

// ----- verif/trajectory_checker.sv -----
// Checker: watches both channels, predicts trajectory results and compares them.
`timescale 1ns / 1ps
module trajectory_checker
  import pptev_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_segment,
  input  logic [1:0]  in_axis,
  input  logic [2:0]  in_coeff_index,
  input  logic [63:0] in_coeff_value,
  input  logic [31:0] in_seg_start,
  input  logic [31:0] in_seg_length,
  input  logic [31:0] in_query_time,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  out_deriv_order,
  input  logic [63:0] out_x,
  input  logic [63:0] out_y,
  input  logic [63:0] out_z,
  input  logic [63:0] out_yaw,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [2:0]  order;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] yaw;
    logic        last;
  } sample_t;

  logic [63:0] coeffs [MAX_SEGMENTS][4][8];
  logic [31:0] seg_starts [MAX_SEGMENTS];
  logic [31:0] seg_lengths [MAX_SEGMENTS];
  logic [4:0]  seg_count_reg;
  logic [31:0] end_time_reg;
  sample_t     expected_samples [$];

  assign pending_count = expected_samples.size();

  function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
    if (v > 128'sh7fff_ffff_ffff_ffff) return SAT_MAX;
    if (v < -128'sh8000_0000_0000_0000) return SAT_MIN;
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] horner(input int seg, input int ax,
                                                input logic [31:0] t, input int d);
    logic signed [127:0] acc;
    logic signed [127:0] term;
    longint k;
    acc = 0;
    for (int i = 7; i >= d; i--) begin
      k = 1;
      for (int j = 0; j < d; j++) k = k * (i - j);
      if (i != 7) acc = sat64((acc * $signed({96'd0, t})) >>> 24);
      term = $signed(coeffs[seg][ax][i]) * k;
      acc = sat64(sat64(term) + acc);
    end
    return acc[63:0];
  endfunction

  task automatic predict_query(input logic [31:0] qt);
    int cnt, pick;
    logic [31:0] tq, loc;
    logic [32:0] wend;
    bit found;
    sample_t r;
    cnt = int'(seg_count_reg);
    if (cnt < 1) cnt = 1;
    if (cnt > MAX_SEGMENTS) cnt = MAX_SEGMENTS;
    tq = (qt > end_time_reg) ? end_time_reg : qt;
    found = 0;
    pick = cnt - 1;
    loc = seg_lengths[pick];
    for (int s = 0; s < cnt; s++) begin
      wend = {1'b0, seg_starts[s]} + {1'b0, seg_lengths[s]};
      if (!found && tq >= seg_starts[s] && {1'b0, tq} <= wend) begin
        found = 1;
        pick = s;
        loc = tq - seg_starts[s];
      end
    end
    for (int d = 0; d < 5; d++) begin
      r.order = 3'(d);
      r.x = horner(pick, 0, loc, d);
      r.y = horner(pick, 1, loc, d);
      r.z = horner(pick, 2, loc, d);
      r.yaw = (d < 2) ? horner(pick, 3, loc, d) : 64'd0;
      r.last = (d == 4);
      expected_samples.insert(expected_samples.size(), r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    sample_t e;
    if (!rst_n) begin
      seg_count_reg <= 5'd1;
      end_time_reg <= '0;
      fail_count = 0;
      expected_samples.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_SEG_COUNT) seg_count_reg <= cfg_data[4:0];
        else end_time_reg <= cfg_data;
      end
      if (push && !full) begin
        case (in_req_type)
          REQ_COEFF: coeffs[in_segment][in_axis][in_coeff_index] = in_coeff_value;
          REQ_TIMING: begin
            seg_starts[in_segment] = in_seg_start;
            seg_lengths[in_segment] = in_seg_length;
          end
          REQ_EVAL: predict_query(in_query_time);
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected transfer", {61'd0, out_deriv_order}, 64'd0);
        end else begin
          e = expected_samples.pop_front();
          if (out_deriv_order !== e.order)
            report_mismatch("order", 64'(out_deriv_order), 64'(e.order));
          if (out_x !== e.x) report_mismatch("x", out_x, e.x);
          if (out_y !== e.y) report_mismatch("y", out_y, e.y);
          if (out_z !== e.z) report_mismatch("z", out_z, e.z);
          if (out_yaw !== e.yaw) report_mismatch("yaw", out_yaw, e.yaw);
          if (out_last !== e.last) report_mismatch("last", 64'(out_last), 64'(e.last));
        end
      end
    end
  end

endmodule

// ----- verif/tb_piecewise_poly_trajectory_eval_top.sv -----
// Testbench top: drives writes, queries and config, and gives the verdict.
`timescale 1ns / 1ps
module tb_piecewise_poly_trajectory_eval_top;
  import pptev_pkg::*;

  logic clk, rst_n;
  logic cfg_wr_en, cfg_index;
  logic [31:0] cfg_data;
  logic push, full, empty, pop;
  logic [1:0] in_req_type, in_axis;
  logic [3:0] in_segment;
  logic [2:0] in_coeff_index, out_deriv_order;
  logic [63:0] in_coeff_value, out_x, out_y, out_z, out_yaw;
  logic [31:0] in_seg_start, in_seg_length, in_query_time;
  logic out_last;
  int fail_count, pending_count;
  int quiet_cycles;
  bit hold_pop, no_idle;

  piecewise_poly_trajectory_eval_top DUT (.*);
  trajectory_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
  end

  // receiver
  initial begin
    pop = 0;
    hold_pop = 0;
    forever begin
      @(posedge clk);
      pop <= !hold_pop && (no_idle || $urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb_piecewise_poly_trajectory_eval_top NOT OK");
      $finish;
    end
  end

  function automatic logic [63:0] rand_coeff();
    case ($urandom_range(5))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return {$urandom, $urandom};
      default: return 64'($signed($urandom_range(2000)) - 1000) <<< $urandom_range(44);
    endcase
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(4))
      0: return 32'hffff_ffff;
      1: return 32'd0;
      2: return $urandom;
      default: return $urandom_range(32'h0800_0000);
    endcase
  endfunction

  task automatic send(input req_t rt, input int seg, input int ax, input int ci,
                      input logic [63:0] cv, input logic [31:0] st,
                      input logic [31:0] ln, input logic [31:0] qt);
    if (!no_idle) begin
      while ($urandom_range(99) < 6) begin
        push <= 0;
        @(posedge clk);
      end
    end
    push <= 1;
    in_req_type <= rt;
    in_segment <= 4'(seg);
    in_axis <= 2'(ax);
    in_coeff_index <= 3'(ci);
    in_coeff_value <= cv;
    in_seg_start <= st;
    in_seg_length <= ln;
    in_query_time <= qt;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [31:0] val);
    push <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic load_all(input int n, input bit rnd);
    for (int s = 0; s < n; s++) begin
      send(REQ_TIMING, s, 0, 0, 0, rnd ? rand_time() : 32'(s) << 24,
           rnd ? rand_time() : 32'h0100_0000, 0);
      for (int a = 0; a < 4; a++)
        for (int i = 0; i < 8; i++)
          send(REQ_COEFF, s, a, i, rnd ? rand_coeff() : 64'(i + 1) << 40, 0, 0, 0);
    end
  endtask

  task automatic query(input logic [31:0] qt);
    send(REQ_EVAL, $urandom, $urandom, $urandom, {$urandom, $urandom}, $urandom,
         $urandom, qt);
  endtask

  initial begin
    push = 0;
    cfg_wr_en = 0;
    cfg_index = CFG_SEG_COUNT;
    cfg_data = 0;
    no_idle = 0;
    {in_req_type, in_segment, in_axis, in_coeff_index} = '0;
    {in_coeff_value, in_seg_start, in_seg_length, in_query_time} = '0;
    @(posedge clk iff rst_n);

    // directed: segments 0 to 2 are the ones queries may use
    load_all(3, 0);
    send(REQ_COEFF, 0, 3, 7, SAT_MAX, 0, 0, 0);
    send(REQ_COEFF, 0, 0, 7, SAT_MIN, 0, 0, 0);
    send(req_t'(2'd3), 15, 3, 7, '1, '1, '1, '1);
    query(32'h0080_0000);
    query(32'hffff_ffff);
    write_cfg(CFG_END_TIME, 32'hffff_ffff);
    write_cfg(CFG_SEG_COUNT, 32'd3);
    query(0);
    query(32'h0180_0000);
    query(32'hffff_ffff);
    query(32'h0300_0000);
    write_cfg(CFG_SEG_COUNT, 32'd0);
    query(32'h0500_0000);
    write_cfg(CFG_SEG_COUNT, 32'd31);
    query(32'h0080_0000);
    write_cfg(CFG_SEG_COUNT, 32'd3);
    send(REQ_TIMING, 2, 0, 0, 0, 32'hffff_ff00, 32'hffff_ffff, 0);
    query(32'hffff_fff0);

    // random
    for (int phase = 0; phase < 3; phase++) begin
      write_cfg(CFG_SEG_COUNT, $urandom_range(3));
      write_cfg(CFG_END_TIME, phase == 0 ? 32'd0 : rand_time());
      no_idle = (phase == 2);
      if (phase == 1) begin
        fork
          begin
            hold_pop = 1;
            repeat (3000) @(posedge clk);
            hold_pop = 0;
          end
        join_none
      end
      for (int n = 0; n < 14; n++) begin
        case ($urandom_range(9))
          0, 1: send(REQ_COEFF, $urandom_range(2), $urandom, $urandom, rand_coeff(),
                     0, 0, 0);
          2: send(REQ_TIMING, $urandom, 0, 0, 0, rand_time(), rand_time(), 0);
          3: send(req_t'(2'd3), $urandom, $urandom, $urandom, {$urandom, $urandom},
                  $urandom, $urandom, $urandom);
          default: query(rand_time());
        endcase
      end
    end
    no_idle = 0;
    push <= 0;

    while (pending_count != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    if (fail_count == 0) $display("tb_piecewise_poly_trajectory_eval_top OK");
    else $display("tb_piecewise_poly_trajectory_eval_top NOT OK");
    $finish;
  end

endmodule
